// ===== rtl/core/tlv_pkg.sv =====
// Package for the record region parser: sizes, cause and status codes.
// No dependencies.
package tlv_pkg;
   localparam int MaxRegionBytes = 65536;
   localparam int SeenDepth      = 512;
   localparam int CountWidth     = $clog2(MaxRegionBytes + 1);
   localparam int SeenAddrWidth  = (SeenDepth > 1) ? $clog2(SeenDepth) : 1;
   localparam int FillWidth      = $clog2(SeenDepth + 1);
   localparam int QueueDepth     = 4;
   localparam int QueueAddrWidth = $clog2(QueueDepth);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_PROTOCOL = 2'd1;
   localparam logic [1:0] STATUS_CAPABILITY = 2'd2;

   localparam logic [3:0] CAUSE_NONE      = 4'd0;
   localparam logic [3:0] CAUSE_TRUNC_HDR = 4'd1;
   localparam logic [3:0] CAUSE_BAD_FLAGS = 4'd2;
   localparam logic [3:0] CAUSE_BAD_LEN   = 4'd3;
   localparam logic [3:0] CAUSE_TRUNC_PAD = 4'd4;
   localparam logic [3:0] CAUSE_PAD_DIRTY = 4'd5;
   localparam logic [3:0] CAUSE_DUPLICATE = 4'd6;
   localparam logic [3:0] CAUSE_TOO_MANY  = 4'd7;
   localparam logic [3:0] CAUSE_BAD_TOPO  = 4'd8;
   localparam logic [3:0] CAUSE_UNK_CRIT  = 4'd9;

   localparam logic [15:0] TYPE_TOPOLOGY = 16'd1;
   localparam logic [31:0] TOPO_LENGTH   = 32'd24;

   // Record or end-of-region summary passed from front to back
   typedef struct packed {
      logic        is_end;      // end of region
      logic [3:0]  cause;       // front cause (latched or end-time)
      logic [15:0] rec_type;
      logic        critical;
      logic        topo_ok;     // type 1 with flags 1, length 24
      logic        topo_bad;    // type 1 otherwise
      logic        pad_dirty;
      logic [63:0] job_hi;
      logic [63:0] job_lo;
      logic [31:0] rank;
      logic [31:0] world;
   } work_type;
endpackage

// ===== rtl/core/tlv_if.sv =====
// Valid/ready channel interfaces for the parser.
// No dependencies.
interface tlv_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface tlv_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  cause;
   logic        topology_present;
   logic [63:0] job_id_high;
   logic [63:0] job_id_low;
   logic [31:0] rank_out;
   logic [31:0] world_size_out;
   modport source (output valid, output status, output cause, output topology_present,
                   output job_id_high, output job_id_low, output rank_out,
                   output world_size_out, input ready);
   modport sink   (input valid, input status, input cause, input topology_present,
                   input job_id_high, input job_id_low, input rank_out,
                   input world_size_out, output ready);
endinterface

// ===== rtl/core/tlv_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tlv_ram #(
   parameter int Width = 16,
   parameter int Depth = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/core/tlv_front.sv =====
// Front end: byte framing, header checks, topology capture.
// Depends on tlv_pkg; emits one work entry per record end or region end.
module tlv_front import tlv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic       in_kind,
   input  logic [7:0] in_byte,
   input  logic       q_full,
   output logic       q_push,
   output work_type   q_data
);
   typedef enum logic [1:0] {PH_HEADER, PH_VALUE, PH_PAD} phase_type;

   phase_type             phase_ff;
   logic [CountWidth-1:0] count_ff;
   logic [63:0]           hdr_ff;
   logic [31:0]           left_ff;
   logic [2:0]            pad_ff;
   logic                  dirty_ff;
   logic [3:0]            err_ff;
   logic [63:0]           hi_ff, lo_ff;
   logic [31:0]           rank_ff, world_ff;

   logic        take;
   logic        live;
   logic [63:0] hdr_in;
   logic [15:0] h_type, h_flags;
   logic [31:0] h_len;
   logic        capture;
   logic [4:0]  idx;
   logic [2:0]  pad_in;
   logic [3:0]  end_cause;

   assign in_ready = !q_full;
   assign take     = in_valid && in_ready;
   assign live     = (err_ff == CAUSE_NONE) && (count_ff < CountWidth'(MaxRegionBytes));
   assign hdr_in   = {hdr_ff[55:0], in_byte};
   assign h_type   = hdr_ff[63:48];
   assign h_flags  = hdr_ff[47:32];
   assign h_len    = hdr_ff[31:0];
   assign capture  = (h_type == TYPE_TOPOLOGY) && (h_flags == 16'd1) && (h_len == TOPO_LENGTH);
   assign idx      = 5'(TOPO_LENGTH - left_ff);
   assign pad_in   = 3'(32'd0 - hdr_in[31:0]);

   // Cause at region end: the latched error, else one from the framing phase
   always_comb begin
      end_cause = err_ff;
      if (err_ff == CAUSE_NONE) begin
         case (phase_ff)
            PH_HEADER: if (count_ff[2:0] != 3'd0) end_cause = CAUSE_TRUNC_HDR;
            PH_VALUE:  end_cause = CAUSE_BAD_LEN;
            PH_PAD:    end_cause = CAUSE_TRUNC_PAD;
            default:   end_cause = err_ff;
         endcase
      end
   end

   // Build the queue entry for a finished record or the end marker
   always_comb begin
      q_data           = '0;
      q_data.rec_type  = h_type;
      q_data.critical  = h_flags[0];
      q_data.topo_ok   = capture;
      q_data.topo_bad  = (h_type == TYPE_TOPOLOGY) && !capture;
      q_data.pad_dirty = dirty_ff;
      q_data.job_hi    = hi_ff;
      q_data.job_lo    = lo_ff;
      q_data.rank      = rank_ff;
      q_data.world     = world_ff;
      q_push           = 1'b0;
      if (take && in_kind) begin
         q_push        = 1'b1;
         q_data.is_end = 1'b1;
         q_data.cause  = end_cause;
      end else if (take && live) begin
         case (phase_ff)
            PH_HEADER: begin
               if (count_ff[2:0] == 3'd7 && hdr_in[47:33] == 15'd0 &&
                   hdr_in[31:0] == 32'd0) begin
                  q_push           = 1'b1;
                  q_data.rec_type  = hdr_in[63:48];
                  q_data.critical  = hdr_in[32];
                  q_data.topo_ok   = 1'b0;
                  q_data.topo_bad  = hdr_in[63:48] == TYPE_TOPOLOGY;
                  q_data.pad_dirty = 1'b0;
               end
            end
            PH_VALUE: q_push = (left_ff == 32'd1) && (pad_ff == 3'd0);
            PH_PAD: begin
               q_push = pad_ff == 3'd1;
               q_data.pad_dirty = dirty_ff || (in_byte != 8'd0);
            end
            default: q_push = 1'b0;
         endcase
      end
   end

   // Advance the framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         count_ff <= '0;
         hdr_ff   <= '0;
         left_ff  <= '0;
         pad_ff   <= '0;
         dirty_ff <= 1'b0;
         err_ff   <= CAUSE_NONE;
         hi_ff    <= '0;
         lo_ff    <= '0;
         rank_ff  <= '0;
         world_ff <= '0;
      end else if (take && in_kind) begin
         phase_ff <= PH_HEADER;
         count_ff <= '0;
         hdr_ff   <= '0;
         left_ff  <= '0;
         pad_ff   <= '0;
         dirty_ff <= 1'b0;
         err_ff   <= CAUSE_NONE;
         hi_ff    <= '0;
         lo_ff    <= '0;
         rank_ff  <= '0;
         world_ff <= '0;
      end else if (take && live) begin
         count_ff <= count_ff + 1'b1;
         case (phase_ff)
            PH_HEADER: begin
               hdr_ff <= hdr_in;
               if (count_ff[2:0] == 3'd7) begin
                  if (hdr_in[47:33] != 15'd0) begin
                     err_ff <= CAUSE_BAD_FLAGS;
                  end else begin
                     left_ff  <= hdr_in[31:0];
                     pad_ff   <= pad_in;
                     dirty_ff <= 1'b0;
                     if (hdr_in[63:48] == TYPE_TOPOLOGY && hdr_in[47:32] == 16'd1 &&
                         hdr_in[31:0] == TOPO_LENGTH) begin
                        hi_ff    <= '0;
                        lo_ff    <= '0;
                        rank_ff  <= '0;
                        world_ff <= '0;
                     end
                     if (hdr_in[31:0] != 32'd0) phase_ff <= PH_VALUE;
                  end
               end
            end
            PH_VALUE: begin
               if (capture) begin
                  if (idx < 5'd16) begin
                     hi_ff <= {hi_ff[55:0], lo_ff[63:56]};
                     lo_ff <= {lo_ff[55:0], in_byte};
                  end else if (idx < 5'd20) begin
                     rank_ff <= {rank_ff[23:0], in_byte};
                  end else begin
                     world_ff <= {world_ff[23:0], in_byte};
                  end
               end
               left_ff <= left_ff - 1'b1;
               if (left_ff == 32'd1) phase_ff <= (pad_ff != 3'd0) ? PH_PAD : PH_HEADER;
            end
            PH_PAD: begin
               if (in_byte != 8'd0) dirty_ff <= 1'b1;
               pad_ff <= pad_ff - 1'b1;
               if (pad_ff == 3'd1) phase_ff <= PH_HEADER;
            end
            default: phase_ff <= PH_HEADER;
         endcase
      end
   end
endmodule

// ===== rtl/core/tlv_queue.sv =====
// Short FIFO of work entries between front and back.
// Depends on tlv_pkg.
module tlv_queue import tlv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output work_type head
);
   work_type                slot_ff [QueueDepth];
   logic [QueueAddrWidth-1:0] wr_ff, rd_ff;
   logic [QueueAddrWidth:0]   used_ff;

   assign full  = used_ff == (QueueAddrWidth+1)'(QueueDepth);
   assign empty = used_ff == '0;
   assign head  = slot_ff[rd_ff];

   // Store on push, advance on pop
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         used_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         used_ff <= used_ff + (QueueAddrWidth+1)'(push) - (QueueAddrWidth+1)'(pop);
      end
   end
endmodule

// ===== rtl/core/tlv_back.sv =====
// Back end: duplicate search over the seen-type memory, record checks, result.
// Depends on tlv_pkg, tlv_if and tlv_ram.
module tlv_back import tlv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_head,
   output logic     q_pop,
   tlv_rsp_if.source rsp
);
   typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_SEND} state_type;

   state_type              state_ff;
   logic [FillWidth-1:0]   fill_ff, scan_ff;
   logic [3:0]             err_ff;
   logic                   topo_ff;
   logic [63:0]            hi_ff, lo_ff;
   logic [31:0]            rank_ff, world_ff;
   logic                   wr_en;
   logic [15:0]            rd_data;
   logic [3:0]             cause;

   tlv_ram #(.Width(16), .Depth(SeenDepth)) u_seen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[SeenAddrWidth-1:0]),
      .wr_data (q_head.rec_type),
      .rd_addr (scan_ff[SeenAddrWidth-1:0]),
      .rd_data (rd_data)
   );

   assign cause = (err_ff != CAUSE_NONE) ? err_ff : q_head.cause;
   assign wr_en = (state_ff == S_READ) && (scan_ff == fill_ff) && (err_ff == CAUSE_NONE) &&
                  (fill_ff < FillWidth'(SeenDepth));
   assign q_pop = (state_ff == S_READ && scan_ff == fill_ff) ||
                  (state_ff == S_CMP && rd_data == q_head.rec_type) ||
                  (state_ff == S_SEND && rsp.ready);

   // Sequence each entry: scan, check, commit or report
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         scan_ff   <= '0;
         err_ff    <= CAUSE_NONE;
         topo_ff   <= 1'b0;
         rsp.valid <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               scan_ff <= '0;
               if (!q_empty) begin
                  if (q_head.is_end) begin
                     rsp.valid            <= 1'b1;
                     rsp.cause            <= cause;
                     rsp.status           <= (cause == CAUSE_NONE) ? STATUS_OK :
                                             (cause == CAUSE_UNK_CRIT) ? STATUS_CAPABILITY :
                                             STATUS_PROTOCOL;
                     rsp.topology_present <= (cause == CAUSE_NONE) && topo_ff;
                     rsp.job_id_high      <= (cause == CAUSE_NONE && topo_ff) ? q_head.job_hi : '0;
                     rsp.job_id_low       <= (cause == CAUSE_NONE && topo_ff) ? q_head.job_lo : '0;
                     rsp.rank_out         <= (cause == CAUSE_NONE && topo_ff) ? q_head.rank : '0;
                     rsp.world_size_out   <= (cause == CAUSE_NONE && topo_ff) ? q_head.world : '0;
                     state_ff             <= S_SEND;
                  end else if (err_ff != CAUSE_NONE) begin
                     state_ff <= S_READ;
                     scan_ff  <= fill_ff;
                  end else if (q_head.pad_dirty) begin
                     err_ff   <= CAUSE_PAD_DIRTY;
                     state_ff <= S_READ;
                     scan_ff  <= fill_ff;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               if (scan_ff == fill_ff) begin
                  state_ff <= S_IDLE;
                  if (err_ff == CAUSE_NONE) begin
                     if (fill_ff >= FillWidth'(SeenDepth)) begin
                        err_ff <= CAUSE_TOO_MANY;
                     end else begin
                        fill_ff <= fill_ff + 1'b1;
                        if (q_head.topo_bad)      err_ff  <= CAUSE_BAD_TOPO;
                        else if (q_head.topo_ok)  topo_ff <= 1'b1;
                        else if (q_head.critical) err_ff  <= CAUSE_UNK_CRIT;
                     end
                  end
               end else begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (rd_data == q_head.rec_type) begin
                  err_ff   <= CAUSE_DUPLICATE;
                  state_ff <= S_IDLE;
               end else begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_SEND: begin
               if (rsp.ready) begin
                  rsp.valid <= 1'b0;
                  state_ff  <= S_IDLE;
                  fill_ff   <= '0;
                  err_ff    <= CAUSE_NONE;
                  topo_ff   <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/core/tlv_record_region_parser.sv =====
// Record region parser. Front takes one byte per cycle unless the queue is full;
// records queue (4 deep) to the back end, whose duplicate scan reads and compares
// each stored type in turn. Sustained rate is one byte a cycle while scans fit
// in the record spacing. An idle back end registers the result from an end marker.
// Synchronous reset clears all control state; the seen-type memory is not cleared.
module tlv_record_region_parser import tlv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tlv_req_if.sink   req,
   tlv_rsp_if.source rsp
);
   logic     q_push, q_full, q_pop, q_empty;
   work_type q_in, q_head;

   tlv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .in_kind  (req.kind),
      .in_byte  (req.data_byte),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   tlv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   tlv_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );
endmodule

// ===== sim/tb_tlv_record_region_parser.sv =====
// Testbench for the record region parser: directed table, then random regions.
// Depends on tlv_pkg, tlv_if and the parser RTL.
module tb_tlv_record_region_parser;
   import tlv_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   tlv_req_if req ();
   tlv_rsp_if rsp ();

   tlv_record_region_parser u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  cause;
      logic        topo;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [31:0] rank;
      logic [31:0] world;
   } outcome_type;

   typedef enum logic [1:0] {PH_HDR = 2'd0, PH_VAL = 2'd1, PH_PAD = 2'd2} phase_type;

   // predictor state
   int unsigned p_count;
   phase_type   p_phase;
   logic [63:0] p_hdr;
   logic [31:0] p_vleft;
   logic [2:0]  p_pleft;
   logic [15:0] p_seen [SeenDepth];
   int unsigned p_fill;
   logic [3:0]  p_err;
   logic        p_topo;
   logic [63:0] p_hi, p_lo;
   logic [31:0] p_rank, p_world;
   logic        p_dirty;

   outcome_type outcome_q[$];
   int          errors = 0;
   int          n_results = 0;
   int          n_items = 0;

   function automatic void parser_clear();
      p_count = 0; p_phase = PH_HDR; p_hdr = '0; p_vleft = '0; p_pleft = '0;
      p_fill = 0; p_err = CAUSE_NONE; p_topo = 1'b0; p_hi = '0; p_lo = '0;
      p_rank = '0; p_world = '0; p_dirty = 1'b0;
   endfunction

   function automatic void note_err(logic [3:0] c);
      if (p_err == CAUSE_NONE) p_err = c;
   endfunction

   function automatic bit is_topo_hdr();
      return p_hdr[63:48] == TYPE_TOPOLOGY && p_hdr[47:32] == 16'd1 &&
             p_hdr[31:0] == TOPO_LENGTH;
   endfunction

   function automatic void close_record();
      logic [15:0] t;
      t = p_hdr[63:48];
      p_phase = PH_HDR;
      if (p_dirty) begin
         note_err(CAUSE_PAD_DIRTY);
         return;
      end
      for (int i = 0; i < p_fill; i++)
         if (p_seen[i] == t) begin
            note_err(CAUSE_DUPLICATE);
            return;
         end
      if (p_fill >= SeenDepth) begin
         note_err(CAUSE_TOO_MANY);
         return;
      end
      p_seen[p_fill] = t;
      p_fill++;
      if (t == TYPE_TOPOLOGY) begin
         if (p_hdr[47:32] != 16'd1 || p_hdr[31:0] != TOPO_LENGTH) note_err(CAUSE_BAD_TOPO);
         else p_topo = 1'b1;
      end else if (p_hdr[32]) begin
         note_err(CAUSE_UNK_CRIT);
      end
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      logic [2:0] pos;
      int unsigned idx;
      pos = p_count[2:0];
      if (p_err != CAUSE_NONE || p_count >= MaxRegionBytes) return;
      p_count++;
      case (p_phase)
         PH_HDR: begin
            p_hdr = {p_hdr[55:0], b};
            if (pos != 3'd7) return;
            if (p_hdr[47:33] != '0) begin
               note_err(CAUSE_BAD_FLAGS);
               return;
            end
            p_vleft = p_hdr[31:0];
            p_pleft = 3'(0 - p_vleft);
            p_dirty = 1'b0;
            if (is_topo_hdr()) begin
               p_hi = '0; p_lo = '0; p_rank = '0; p_world = '0;
            end
            if (p_vleft != 0) p_phase = PH_VAL;
            else if (p_pleft != 0) p_phase = PH_PAD;
            else close_record();
         end
         PH_VAL: begin
            if (is_topo_hdr()) begin
               idx = 24 - p_vleft;
               if (idx < 16) begin
                  p_hi = {p_hi[55:0], p_lo[63:56]};
                  p_lo = {p_lo[55:0], b};
               end else if (idx < 20) p_rank = {p_rank[23:0], b};
               else p_world = {p_world[23:0], b};
            end
            p_vleft--;
            if (p_vleft == 0) begin
               if (p_pleft != 0) p_phase = PH_PAD;
               else close_record();
            end
         end
         default: begin
            if (b != 0) p_dirty = 1'b1;
            p_pleft--;
            if (p_pleft == 0) close_record();
         end
      endcase
   endfunction

   function automatic outcome_type region_outcome();
      outcome_type o;
      logic [3:0] c;
      bit ok;
      c = p_err;
      if (c == CAUSE_NONE) begin
         if (p_phase == PH_HDR && p_count[2:0] != 0) c = CAUSE_TRUNC_HDR;
         else if (p_phase == PH_VAL) c = CAUSE_BAD_LEN;
         else if (p_phase == PH_PAD) c = CAUSE_TRUNC_PAD;
      end
      ok = c == CAUSE_NONE && p_topo;
      o.status = c == CAUSE_NONE ? STATUS_OK :
                 (c == CAUSE_UNK_CRIT ? STATUS_CAPABILITY : STATUS_PROTOCOL);
      o.cause = c;
      o.topo = ok;
      o.hi = ok ? p_hi : '0;
      o.lo = ok ? p_lo : '0;
      o.rank = ok ? p_rank : '0;
      o.world = ok ? p_world : '0;
      parser_clear();
      return o;
   endfunction

   // stimulus store: kind, byte, optional typed-in outcome
   typedef struct {
      logic        kind;
      logic [7:0]  b;
      bit          fixed;
      outcome_type want;
   } beat_type;
   beat_type beats[$];

   function automatic void push_byte(logic [7:0] b);
      beat_type x;
      x.kind = 1'b0; x.b = b; x.fixed = 0; x.want = '0;
      beats.push_back(x);
   endfunction

   function automatic void push_end(logic [7:0] junk, bit fixed, outcome_type w);
      beat_type x;
      x.kind = 1'b1; x.b = junk; x.fixed = fixed; x.want = w;
      beats.push_back(x);
   endfunction

   function automatic void push_hdr(logic [15:0] t, logic [15:0] f, logic [31:0] len);
      logic [63:0] h;
      h = {t, f, len};
      for (int i = 7; i >= 0; i--) push_byte(h[i*8 +: 8]);
   endfunction

   function automatic outcome_type err_out(logic [3:0] c);
      outcome_type o;
      o = '0;
      o.cause = c;
      o.status = c == CAUSE_UNK_CRIT ? STATUS_CAPABILITY : STATUS_PROTOCOL;
      return o;
   endfunction

   // record with value bytes and padding; dirty makes the last pad byte nonzero, if any
   function automatic void push_record(logic [15:0] t, logic [15:0] f, int len, bit dirty);
      int pad;
      push_hdr(t, f, len);
      for (int i = 0; i < len; i++) push_byte(8'($urandom));
      pad = (8 - len % 8) % 8;
      for (int i = 0; i < pad; i++)
         push_byte((dirty && i == pad - 1) ? 8'($urandom_range(1, 255)) : 8'h00);
   endfunction

   function automatic void push_topo();
      push_hdr(TYPE_TOPOLOGY, 16'd1, TOPO_LENGTH);
      for (int i = 0; i < 24; i++) push_byte(8'($urandom));
   endfunction

   function automatic void build_directed();
      outcome_type ok0;
      ok0 = '0;
      push_end(8'hFF, 1, ok0);                               // empty region
      push_byte(8'h00); push_end(8'h00, 1, err_out(CAUSE_TRUNC_HDR));
      push_hdr(16'd5, 16'h8000, 32'd0); push_end(8'h00, 1, err_out(CAUSE_BAD_FLAGS));
      push_hdr(16'd5, 16'd0, 32'hFFFF_FFFF); push_end(8'h00, 1, err_out(CAUSE_BAD_LEN));
      push_hdr(16'd5, 16'd0, 32'd3); push_byte(8'd1); push_byte(8'd2); push_byte(8'd3);
      push_end(8'h00, 1, err_out(CAUSE_TRUNC_PAD));
      push_record(16'd5, 16'd0, 3, 1); push_end(8'h00, 1, err_out(CAUSE_PAD_DIRTY));
      push_record(16'hFFFF, 16'd0, 0, 0); push_record(16'hFFFF, 16'd0, 8, 0);
      push_end(8'h00, 1, err_out(CAUSE_DUPLICATE));
      push_record(16'd1, 16'd0, 24, 0); push_end(8'h00, 1, err_out(CAUSE_BAD_TOPO));
      push_record(16'd1, 16'd1, 8, 0); push_end(8'h00, 1, err_out(CAUSE_BAD_TOPO));
      push_record(16'd9, 16'd1, 1, 0); push_end(8'h00, 1, err_out(CAUSE_UNK_CRIT));
      push_record(16'd0, 16'd0, 5, 0); push_topo(); push_end(8'h00, 0, ok0);
   endfunction

   function automatic void build_random(int goal);
      int n, len, sel;
      outcome_type ok0;
      ok0 = '0;
      while (beats.size() < goal) begin
         n = $urandom_range(0, 5);
         for (int r = 0; r < n; r++) begin
            sel = $urandom_range(0, 19);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 9);
            if (sel == 0) push_topo();
            else if (sel == 1) push_record(16'($urandom_range(0, 12)), 16'($urandom), len, 0);
            else if (sel == 2) push_record(16'($urandom_range(0, 12)), 16'd0, len, 1);
            else if (sel == 3) push_byte(8'($urandom));
            else if (sel == 4) push_record(16'($urandom), {15'd0, 1'($urandom)}, len, 0);
            else push_record(16'($urandom_range(0, 30)), 16'd0, len, 0);
         end
         if ($urandom_range(0, 4) == 0) push_hdr(16'($urandom), 16'd0, 32'($urandom));
         push_end(8'($urandom), 0, ok0);
      end
   endfunction

   outcome_type typed_q[$];
   bit          typed_flag_q[$];
   bit          stim_done = 0;

   task automatic check_result();
      outcome_type got, exp, typed;
      bit fixed;
      got = {rsp.status, rsp.cause, rsp.topology_present, rsp.job_id_high,
             rsp.job_id_low, rsp.rank_out, rsp.world_size_out};
      n_results++;
      if (outcome_q.size() == 0) begin
         $display("%0t unexpected result %h", $time, got);
         errors++;
         return;
      end
      exp = outcome_q.pop_front();
      typed = typed_q.pop_front();
      fixed = typed_flag_q.pop_front();
      if (fixed && typed != exp) begin
         $display("%0t table row disagrees: table %h predictor %h", $time, typed, exp);
         errors++;
      end
      if (got.status != exp.status) begin
         $display("%0t status exp %0d got %0d", $time, exp.status, got.status); errors++;
      end
      if (got.cause != exp.cause) begin
         $display("%0t cause exp %0d got %0d", $time, exp.cause, got.cause); errors++;
      end
      if (got.topo != exp.topo) begin
         $display("%0t topology exp %0d got %0d", $time, exp.topo, got.topo); errors++;
      end
      if (got.hi != exp.hi) begin
         $display("%0t job_hi exp %h got %h", $time, exp.hi, got.hi); errors++;
      end
      if (got.lo != exp.lo) begin
         $display("%0t job_lo exp %h got %h", $time, exp.lo, got.lo); errors++;
      end
      if (got.rank != exp.rank) begin
         $display("%0t rank exp %h got %h", $time, exp.rank, got.rank); errors++;
      end
      if (got.world != exp.world) begin
         $display("%0t world exp %h got %h", $time, exp.world, got.world); errors++;
      end
   endtask

   // sender
   initial begin
      int gap;
      req.valid = 1'b0; req.kind = 1'b0; req.data_byte = '0;
      parser_clear();
      build_directed();
      build_random(1350);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (beats[i]) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (i > 600 && i < 900) gap = 0;
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req.valid <= 1'b1;
         req.kind <= beats[i].kind;
         req.data_byte <= beats[i].b;
         @(posedge clock);
         while (!req.ready) @(posedge clock);
         n_items++;
         if (beats[i].kind == 1'b0) parse_byte(beats[i].b);
         else begin
            outcome_q.push_back(region_outcome());
            typed_q.push_back(beats[i].want);
            typed_flag_q.push_back(beats[i].fixed);
         end
      end
      req.valid <= 1'b0;
      stim_done = 1;
   end

   // receiver with random stalls
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (n_results > 40 && n_results < 70) stall = 0;
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         check_result();
      end
   end

   // end of run: drain, settle, report
   initial begin
      wait (stim_done);
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (outcome_q.size() != 0) errors++;
      $display("covered %0d beats and %0d region results, directed and random",
               n_items, n_results);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end
endmodule
